// ===== src/lfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants of the lru frame replacer
// Request kinds, field widths and the structs passed between the modules.
// ----------------------------------------------------------------------------
package lfr_pkg;

   // field widths fixed by the request and result formats
   localparam int FRAME_W   = 4;
   localparam int MODE_W    = 2;
   localparam int COUNT_W   = 5;
   localparam int FRAME_IDS = 1 << FRAME_W;

   // default store depth and capacity after reset
   localparam int                 FRAME_SLOTS_DEFAULT = 16;
   localparam logic [COUNT_W-1:0] CAPACITY_RESET      = 5'd16;

   // request kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_VICTIM = 2'd0,
      MODE_PIN    = 2'd1,
      MODE_UNPIN  = 2'd2
   } mode_type;

   // one request as held in the input register
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FRAME_W-1:0] frame;
   } request_type;

   // one result as produced by the store
   typedef struct packed {
      logic               victim_valid;
      logic [FRAME_W-1:0] victim_frame;
      logic [COUNT_W-1:0] entry_count;
   } result_type;

endpackage

// ===== src/lfr_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_store: ordered frame list, presence bits and occupancy
// Applies one request per step: parallel compare over all slots, then a
// one-place shift towards the oldest end or a write at the newest end.
// ----------------------------------------------------------------------------
module lfr_store #(
   parameter int FRAME_SLOTS = lfr_pkg::FRAME_SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  lfr_pkg::request_type        req,
   input  logic [lfr_pkg::COUNT_W-1:0] capacity,
   output lfr_pkg::result_type         result
);

   logic [lfr_pkg::FRAME_W-1:0] order_ff [FRAME_SLOTS];
   logic [lfr_pkg::FRAME_W-1:0] order_in [FRAME_SLOTS];
   logic [lfr_pkg::FRAME_IDS-1:0] present_ff, present_in;
   logic [lfr_pkg::COUNT_W-1:0]   occ_ff, occ_in;

   logic [FRAME_SLOTS-1:0] match;
   logic [FRAME_SLOTS-1:0] shift_sel;
   logic                   room;
   logic                   hit;

   // compare the requested frame against every held slot
   always_comb begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         match[i] = (32'(occ_ff) > i) && (order_ff[i] == req.frame);
      end
   end

   // slot shifts when the removed entry sits at or below it
   always_comb begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         shift_sel[i] = |(match & ({FRAME_SLOTS{1'b1}} >> (FRAME_SLOTS - 1 - i)));
      end
   end

   assign hit  = present_ff[req.frame];
   assign room = (occ_ff < capacity) && (32'(occ_ff) < FRAME_SLOTS);

   // next state and result
   always_comb begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         order_in[i] = order_ff[i];
      end
      present_in          = present_ff;
      occ_in              = occ_ff;
      result.victim_valid = 1'b0;
      result.victim_frame = '0;
      case (lfr_pkg::mode_type'(req.mode))
         lfr_pkg::MODE_VICTIM: begin
            if (occ_ff != '0) begin
               result.victim_valid    = 1'b1;
               result.victim_frame    = order_ff[0];
               present_in[order_ff[0]] = 1'b0;
               occ_in                 = occ_ff - 1'b1;
               for (int i = 0; i < FRAME_SLOTS - 1; i++) begin
                  order_in[i] = order_ff[i+1];
               end
            end
         end
         lfr_pkg::MODE_PIN: begin
            if (hit) begin
               present_in[req.frame] = 1'b0;
               occ_in                = occ_ff - 1'b1;
               for (int i = 0; i < FRAME_SLOTS - 1; i++) begin
                  if (shift_sel[i]) begin
                     order_in[i] = order_ff[i+1];
                  end
               end
            end
         end
         lfr_pkg::MODE_UNPIN: begin
            if (!hit && room) begin
               present_in[req.frame] = 1'b1;
               occ_in                = occ_ff + 1'b1;
               for (int i = 0; i < FRAME_SLOTS; i++) begin
                  if (32'(occ_ff) == i) begin
                     order_in[i] = req.frame;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      result.entry_count = occ_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         occ_ff     <= '0;
      end else if (step) begin
         present_ff <= present_in;
         occ_ff     <= occ_in;
      end
   end

   // frame list, no reset: slots at or above the count are never read
   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < FRAME_SLOTS; i++) begin
            order_ff[i] <= order_in[i];
         end
      end
   end

   // presence bits and count agree
   a_count_matches_present: assert property (@(posedge clock) disable iff (reset)
      $countones(present_ff) == 32'(occ_ff))
      else $error("presence bits disagree with occupancy");

   // count bounded by the store depth
   a_count_in_store: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= FRAME_SLOTS)
      else $error("occupancy beyond store depth");

   // a victim step on a non-empty list removes exactly one frame
   a_victim_drops_one: assert property (@(posedge clock) disable iff (reset)
      step && (req.mode == lfr_pkg::MODE_VICTIM) && (occ_ff != '0)
      |=> occ_ff == $past(occ_ff) - 1'b1)
      else $error("victim did not drop one entry");

   // pin of an absent frame leaves the list alone
   a_pin_absent_no_change: assert property (@(posedge clock) disable iff (reset)
      step && (req.mode == lfr_pkg::MODE_PIN) && !hit
      |=> $stable(occ_ff) && $stable(present_ff))
      else $error("pin of absent frame changed state");

endmodule

// ===== src/lru_frame_replacer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_replacer: evictable frame set in least recently unpinned order
// Top level: request register, capacity register, store and result register.
// ----------------------------------------------------------------------------
// Each request passes an input register and is applied to the frame list when
// it moves on to the output register, where its result lands; a request can be
// taken every cycle while the result side is not stalled by rsp_tready, so the
// sustained rate is one request per cycle when the receiver keeps up. The work
// of one request is a parallel compare of the frame against every held slot
// followed by a one-place shift of the list, or a write at the newest end. The
// capacity register is written through csr_we/csr_wdata; the user must write it
// only while no request is in flight, which the block itself does not enforce;
// values above FRAME_SLOTS behave as FRAME_SLOTS. No clearing pass after reset.
module lru_frame_replacer #(
   parameter int FRAME_SLOTS = lfr_pkg::FRAME_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] frame, [7:4] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] victim_frame, [8:4] entry_count, [15:9] zero
   output logic        rsp_tuser,   // [0] victim_valid
   // capacity register
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   logic                        in_valid_ff;
   lfr_pkg::request_type        in_req_ff, in_req_in;
   logic                        out_valid_ff;
   lfr_pkg::result_type         out_res_ff;
   lfr_pkg::result_type         store_res;
   logic [lfr_pkg::COUNT_W-1:0] capacity_ff;
   logic                        advance;
   logic                        take;

   // request moves to the result register when that is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_req_in.mode  = req_tuser;
   assign in_req_in.frame = req_tdata[lfr_pkg::FRAME_W-1:0];

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lfr_pkg::CAPACITY_RESET;
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff <= in_req_in;
      end
   end

   lfr_store #(
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req      (in_req_ff),
      .capacity (capacity_ff),
      .result   (store_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= store_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.victim_valid;
   assign rsp_tdata  = {7'b0, out_res_ff.entry_count, out_res_ff.victim_frame};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: request stream check of the lru frame replacer
// Drives victim, pin, unpin and unused requests over several capacity
// settings and idle patterns. A shadow of the frame order list predicts
// every result, and each result is checked field by field as it arrives.
// ----------------------------------------------------------------------------
module testbench;

   localparam int                SLOTS          = lfr_pkg::FRAME_SLOTS_DEFAULT;
   localparam int                FRAME_W        = lfr_pkg::FRAME_W;
   localparam int                MODE_W         = lfr_pkg::MODE_W;
   localparam int                COUNT_W        = lfr_pkg::COUNT_W;
   localparam int                FRAME_IDS      = lfr_pkg::FRAME_IDS;
   localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;
   localparam int                CYCLE_LIMIT    = 200000;
   localparam int                PHASE_COUNT    = 8;
   localparam int                PHASE_ITEMS    = 230;
   localparam int                HOLD_CYCLES    = 300;
   localparam int                SETTLE_CYCLES  = 4;
   localparam int                MISMATCH_SHOWN = 10;

   // shadow of the replacer: frame order, presence, occupancy and capacity
   class lru_shadow;
      logic [FRAME_W-1:0]  order_q [SLOTS];
      bit                  present [FRAME_IDS];
      int unsigned         held;
      logic [COUNT_W-1:0]  capacity;
      lfr_pkg::result_type awaited [$];
      int unsigned         mismatches;

      function new();
         held       = 0;
         capacity   = lfr_pkg::CAPACITY_RESET;
         mismatches = 0;
         foreach (present[i]) present[i] = 1'b0;
         foreach (order_q[i]) order_q[i] = '0;
      endfunction

      // close the gap left by a removed slot
      function void drop_at(int unsigned pos);
         for (int unsigned i = pos; i + 1 < held && i + 1 < SLOTS; i++)
            order_q[i] = order_q[i + 1];
         if (held > 0) held--;
      endfunction

      function lfr_pkg::result_type apply_request(logic [MODE_W-1:0] mode,
                                                  logic [FRAME_W-1:0] frame);
         lfr_pkg::result_type r;
         int unsigned         limit;
         r = '0;
         // capacity above the store saturates
         limit = (capacity > SLOTS) ? SLOTS : capacity;
         case (mode)
            lfr_pkg::MODE_VICTIM: begin
               if (held > 0) begin
                  r.victim_valid = 1'b1;
                  r.victim_frame = order_q[0];
                  present[order_q[0]] = 1'b0;
                  drop_at(0);
               end
            end
            lfr_pkg::MODE_PIN: begin
               if (present[frame]) begin
                  for (int unsigned i = 0; i < held && i < SLOTS; i++) begin
                     if (order_q[i] == frame) begin
                        drop_at(i);
                        break;
                     end
                  end
                  present[frame] = 1'b0;
               end
            end
            lfr_pkg::MODE_UNPIN: begin
               if (!present[frame] && held < limit) begin
                  order_q[held]  = frame;
                  held++;
                  present[frame] = 1'b1;
               end
            end
            default: ;
         endcase
         r.entry_count = COUNT_W'(held);
         return r;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [FRAME_W-1:0] frame);
         awaited.push_back(apply_request(mode, frame));
      endfunction

      function void check_result(logic valid, logic [FRAME_W-1:0] vframe,
                                 logic [COUNT_W-1:0] count);
         lfr_pkg::result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
               $display("unexpected result: valid %0b frame %0d count %0d",
                        valid, vframe, count);
            return;
         end
         want = awaited.pop_front();
         if (want.victim_valid !== valid || want.victim_frame !== vframe ||
             want.entry_count !== count) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
               $display({"result mismatch: expected valid %0b frame %0d count %0d,",
                         " got valid %0b frame %0d count %0d"},
                        want.victim_valid, want.victim_frame, want.entry_count,
                        valid, vframe, count);
         end
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic [1:0]           req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [COUNT_W-1:0]   csr_wdata  = '0;

   lru_shadow   shadow;
   int          cycle_count     = 0;
   int          source_idle_pct = 0;
   int          sink_stall_pct  = 0;
   int          hold_asks       = 0;
   int          holds_served    = 0;
   int          hold_left       = 0;
   int          sent_count      = 0;

   lru_frame_replacer #(.FRAME_SLOTS(SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: check what is taken, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         shadow.check_result(rsp_tuser, rsp_tdata[3:0], rsp_tdata[8:4]);
      if (hold_asks != holds_served) begin
         holds_served <= hold_asks;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
   end

   // offer one request, with random idle cycles ahead of it
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [FRAME_W-1:0] frame);
      while ($urandom_range(0, 99) < source_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, frame};
      do @(posedge clock); while (!req_tready);
      shadow.note_request(mode, frame);
      sent_count++;
   endtask

   // stop offering until every predicted result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [COUNT_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we          <= 1'b0;
      shadow.capacity  = value;
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_caps [PHASE_COUNT];
      logic [FRAME_W-1:0] shuffle [FRAME_IDS];
      logic [FRAME_W-1:0] swap;
      logic [MODE_W-1:0]  mode;
      int                 pick;
      int                 roll;
      int                 phase_start;
      int                 drain_len;
      bit                 held_off;
      bit                 paused;

      shadow     = new();
      phase_caps = '{5'd16, 5'd31, 5'd1, 5'd8, 5'd0, 5'd2, 5'd17, 5'd12};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty victim, absent pin, duplicate unpin, unused mode
      send_request(lfr_pkg::MODE_VICTIM, 4'd15);
      send_request(lfr_pkg::MODE_PIN,    4'd5);
      send_request(lfr_pkg::MODE_UNPIN,  4'd0);
      send_request(lfr_pkg::MODE_UNPIN,  4'd15);
      send_request(lfr_pkg::MODE_UNPIN,  4'd7);
      send_request(lfr_pkg::MODE_UNPIN,  4'd0);
      send_request(MODE_UNUSED,          4'd15);
      send_request(lfr_pkg::MODE_PIN,    4'd15);
      send_request(lfr_pkg::MODE_VICTIM, 4'd0);
      send_request(lfr_pkg::MODE_VICTIM, 4'd0);
      send_request(lfr_pkg::MODE_VICTIM, 4'd15);
      // full set refuses further unpins
      set_capacity(5'd2);
      send_request(lfr_pkg::MODE_UNPIN,  4'd1);
      send_request(lfr_pkg::MODE_UNPIN,  4'd2);
      send_request(lfr_pkg::MODE_UNPIN,  4'd3);
      // capacity lowered below occupancy
      set_capacity(5'd1);
      send_request(lfr_pkg::MODE_UNPIN,  4'd4);
      send_request(lfr_pkg::MODE_VICTIM, 4'd0);
      send_request(lfr_pkg::MODE_UNPIN,  4'd4);
      send_request(lfr_pkg::MODE_VICTIM, 4'd0);
      send_request(lfr_pkg::MODE_UNPIN,  4'd4);
      // zero capacity never inserts
      set_capacity(5'd0);
      send_request(lfr_pkg::MODE_UNPIN,  4'd5);
      send_request(lfr_pkg::MODE_VICTIM, 4'd0);
      send_request(lfr_pkg::MODE_UNPIN,  4'd5);
      // capacity beyond the store
      set_capacity(5'd31);
      send_request(lfr_pkg::MODE_UNPIN,  4'd9);
      send_request(lfr_pkg::MODE_UNPIN,  4'd10);
      send_request(lfr_pkg::MODE_PIN,    4'd9);

      // random phases over capacities and idle patterns
      held_off = 1'b0;
      paused   = 1'b0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_capacity(phase_caps[p]);
         case (p % 4)
            0: begin source_idle_pct = 0;  sink_stall_pct <= 0;  end
            1: begin source_idle_pct = 54; sink_stall_pct <= 0;  end
            2: begin source_idle_pct = 0;  sink_stall_pct <= 54; end
            default: begin source_idle_pct = 16; sink_stall_pct <= 16; end
         endcase
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_ITEMS) begin
            // long receiver hold-off while requests keep coming
            if (p == 0 && !held_off && sent_count - phase_start > 60) begin
               hold_asks <= hold_asks + 1;
               held_off   = 1'b1;
            end
            // sender pause until everything is back
            if (p == 2 && !paused && sent_count - phase_start > 100) begin
               wait_drained();
               paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               // mixed burst of random requests
               repeat (8) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 6)       mode = MODE_UNUSED;
                  else if (pick < 50) mode = lfr_pkg::MODE_UNPIN;
                  else if (pick < 72) mode = lfr_pkg::MODE_PIN;
                  else                mode = lfr_pkg::MODE_VICTIM;
                  send_request(mode, FRAME_W'($urandom_range(0, FRAME_IDS - 1)));
               end
            end else if (roll < 80) begin
               // fill: every frame once in shuffled order, then a repeat
               foreach (shuffle[i]) shuffle[i] = FRAME_W'(i);
               for (int i = FRAME_IDS - 1; i > 0; i--) begin
                  pick          = $urandom_range(0, i);
                  swap          = shuffle[i];
                  shuffle[i]    = shuffle[pick];
                  shuffle[pick] = swap;
               end
               foreach (shuffle[i]) send_request(lfr_pkg::MODE_UNPIN, shuffle[i]);
               send_request(lfr_pkg::MODE_UNPIN, shuffle[$urandom_range(0, FRAME_IDS - 1)]);
            end else begin
               // drain: evict everything and one more on the empty set
               drain_len = shadow.held + 1;
               repeat (drain_len)
                  send_request(lfr_pkg::MODE_VICTIM,
                               FRAME_W'($urandom_range(0, FRAME_IDS - 1)));
            end
         end
      end

      wait_drained();
      if (shadow.mismatches == 0 && shadow.awaited.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
